// ===== design/bsp_pkg.sv =====
// Shared types and constants for the 24-bit BMP stream parser.
// Holds the result record that travels from the parser front end to the output stage.
// No dependencies.
package bsp_pkg;

  localparam int HDR_LEN = 54;

  localparam logic [7:0]  MAGIC_B    = 8'h42;  // 'B'
  localparam logic [7:0]  MAGIC_M    = 8'h4d;  // 'M'
  localparam logic [15:0] PIX_DEPTH  = 16'd24;
  localparam logic [31:0] PIX_OFFSET = 32'(HDR_LEN);

  // byte positions inside the combined file and info header
  localparam logic [5:0] IDX_MAGIC0 = 6'd0;
  localparam logic [5:0] IDX_MAGIC1 = 6'd1;
  localparam logic [5:0] IDX_OFF0   = 6'd10;
  localparam logic [5:0] IDX_OFF1   = 6'd11;
  localparam logic [5:0] IDX_OFF2   = 6'd12;
  localparam logic [5:0] IDX_OFF3   = 6'd13;
  localparam logic [5:0] IDX_WID0   = 6'd18;
  localparam logic [5:0] IDX_WID1   = 6'd19;
  localparam logic [5:0] IDX_WID2   = 6'd20;
  localparam logic [5:0] IDX_WID3   = 6'd21;
  localparam logic [5:0] IDX_HGT0   = 6'd22;
  localparam logic [5:0] IDX_HGT1   = 6'd23;
  localparam logic [5:0] IDX_HGT2   = 6'd24;
  localparam logic [5:0] IDX_HGT3   = 6'd25;
  localparam logic [5:0] IDX_DEP0   = 6'd28;
  localparam logic [5:0] IDX_DEP1   = 6'd29;
  localparam logic [5:0] IDX_CMP0   = 6'd30;
  localparam logic [5:0] IDX_CMP1   = 6'd31;
  localparam logic [5:0] IDX_CMP2   = 6'd32;
  localparam logic [5:0] IDX_CMP3   = 6'd33;
  localparam logic [5:0] IDX_LAST   = 6'(HDR_LEN - 1);

  typedef enum logic [1:0] {
    KIND_PIXEL  = 2'd0,
    KIND_HEADER = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ERR_MAGIC  = 2'd0,
    ERR_OFFSET = 2'd1,
    ERR_FORMAT = 2'd2,
    ERR_SIZE   = 2'd3
  } err_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [11:0] column;
    logic [11:0] row;
    logic        last_pixel;
    err_t        error_code;
    logic [12:0] image_width;
    logic [12:0] image_height;
  } result_t;

  // one result handed from the parser into the queue
  typedef struct packed {
    logic    push;
    result_t res;
  } push_t;

endpackage

// ===== design/bsp_front.sv =====
// Parser front end: takes file bytes, walks the header and the pixel rows.
// Emits at most one result record per byte. Depends on bsp_pkg.
module bsp_front #(
  parameter int MAX_DIM = 4096
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           accept,
  input  logic [7:0]     data_byte,
  input  logic           start_of_file,
  output bsp_pkg::push_t out
);
  import bsp_pkg::*;

  localparam int          DIM_W   = $clog2(MAX_DIM + 1);
  localparam logic [31:0] MAX_D32 = 32'(MAX_DIM);

  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_PIXEL  = 3'd1,
    PH_PAD    = 3'd2,
    PH_DONE   = 3'd3,
    PH_ERROR  = 3'd4
  } phase_t;

  phase_t             phase, phase_next, cur_phase;
  logic [5:0]         header_index, header_index_next, cur_index;
  logic [31:0]        offset_accum, offset_accum_next;
  logic [31:0]        width_accum, width_accum_next;
  logic [31:0]        height_accum, height_accum_next;
  logic [15:0]        depth_accum, depth_accum_next;
  logic [31:0]        compression_accum, compression_accum_next;
  logic [DIM_W-1:0]   column_count, column_count_next, cur_column;
  logic [DIM_W-1:0]   row_count, row_count_next, cur_row;
  logic [1:0]         byte_in_pixel, byte_in_pixel_next, cur_bip;
  logic [7:0]         blue_hold, blue_hold_next;
  logic [7:0]         green_hold, green_hold_next;
  logic [1:0]         pad_left, pad_left_next, cur_pad;
  logic [DIM_W-1:0]   width_dim, height_dim, column_inc, row_inc;
  result_t            res;
  logic               res_valid;

  function automatic logic dim_ok(input logic [31:0] v, input logic [31:0] lim);
    dim_ok = !v[31] && (v != 32'd0) && (v <= lim);
  endfunction

  // once the header passed, both dimensions fit the counter width
  assign width_dim  = width_accum[DIM_W-1:0];
  assign height_dim = height_accum[DIM_W-1:0];

  always_comb begin
    // a start-of-file byte sees the cleared state
    cur_phase  = start_of_file ? PH_HEADER : phase;
    cur_index  = start_of_file ? 6'd0 : header_index;
    cur_column = start_of_file ? '0 : column_count;
    cur_row    = start_of_file ? '0 : row_count;
    cur_bip    = start_of_file ? 2'd0 : byte_in_pixel;
    cur_pad    = start_of_file ? 2'd0 : pad_left;
    column_inc = cur_column + 1'b1;
    row_inc    = cur_row + 1'b1;

    phase_next             = cur_phase;
    header_index_next      = cur_index;
    offset_accum_next      = offset_accum;
    width_accum_next       = width_accum;
    height_accum_next      = height_accum;
    depth_accum_next       = depth_accum;
    compression_accum_next = compression_accum;
    column_count_next      = cur_column;
    row_count_next         = cur_row;
    byte_in_pixel_next     = cur_bip;
    blue_hold_next         = blue_hold;
    green_hold_next        = green_hold;
    pad_left_next          = cur_pad;
    res                    = '0;
    res_valid              = 1'b0;

    unique case (cur_phase)
      PH_HEADER: begin
        header_index_next = cur_index + 6'd1;
        case (cur_index)
          IDX_OFF0: offset_accum_next[7:0]        = data_byte;
          IDX_OFF1: offset_accum_next[15:8]       = data_byte;
          IDX_OFF2: offset_accum_next[23:16]      = data_byte;
          IDX_OFF3: offset_accum_next[31:24]      = data_byte;
          IDX_WID0: width_accum_next[7:0]         = data_byte;
          IDX_WID1: width_accum_next[15:8]        = data_byte;
          IDX_WID2: width_accum_next[23:16]       = data_byte;
          IDX_WID3: width_accum_next[31:24]       = data_byte;
          IDX_HGT0: height_accum_next[7:0]        = data_byte;
          IDX_HGT1: height_accum_next[15:8]       = data_byte;
          IDX_HGT2: height_accum_next[23:16]      = data_byte;
          IDX_HGT3: height_accum_next[31:24]      = data_byte;
          IDX_DEP0: depth_accum_next[7:0]         = data_byte;
          IDX_DEP1: depth_accum_next[15:8]        = data_byte;
          IDX_CMP0: compression_accum_next[7:0]   = data_byte;
          IDX_CMP1: compression_accum_next[15:8]  = data_byte;
          IDX_CMP2: compression_accum_next[23:16] = data_byte;
          IDX_CMP3: compression_accum_next[31:24] = data_byte;
          default: ;
        endcase

        if ((cur_index == IDX_MAGIC0 && data_byte != MAGIC_B) ||
            (cur_index == IDX_MAGIC1 && data_byte != MAGIC_M)) begin
          res_valid      = 1'b1;
          res.kind       = KIND_ERROR;
          res.error_code = ERR_MAGIC;
          phase_next     = PH_ERROR;
        end else if (cur_index == IDX_OFF3 && offset_accum_next != PIX_OFFSET) begin
          res_valid      = 1'b1;
          res.kind       = KIND_ERROR;
          res.error_code = ERR_OFFSET;
          phase_next     = PH_ERROR;
        end else if (cur_index == IDX_LAST) begin
          res_valid = 1'b1;
          if (depth_accum != PIX_DEPTH || compression_accum != 32'd0) begin
            res.kind       = KIND_ERROR;
            res.error_code = ERR_FORMAT;
            phase_next     = PH_ERROR;
          end else if (!dim_ok(width_accum, MAX_D32) || !dim_ok(height_accum, MAX_D32)) begin
            res.kind       = KIND_ERROR;
            res.error_code = ERR_SIZE;
            phase_next     = PH_ERROR;
          end else begin
            res.kind         = KIND_HEADER;
            res.image_width  = width_accum[12:0];
            res.image_height = height_accum[12:0];
            phase_next       = PH_PIXEL;
          end
        end
      end

      PH_PIXEL: begin
        case (cur_bip)
          2'd0: begin
            blue_hold_next     = data_byte;
            byte_in_pixel_next = 2'd1;
          end
          2'd1: begin
            green_hold_next    = data_byte;
            byte_in_pixel_next = 2'd2;
          end
          default: begin
            byte_in_pixel_next = 2'd0;
            res_valid          = 1'b1;
            res.kind           = KIND_PIXEL;
            res.red            = data_byte;
            res.green          = green_hold;
            res.blue           = blue_hold;
            res.column         = 12'(cur_column);
            res.row            = 12'(cur_row);
            res.last_pixel     = (column_inc == width_dim) && (row_inc == height_dim);
            column_count_next  = column_inc;
            if (column_inc >= width_dim) begin
              if (row_inc >= height_dim) begin
                phase_next = PH_DONE;
              end else if (width_accum[1:0] != 2'd0) begin
                // padding per row equals width mod 4 for three-byte pixels
                pad_left_next = width_accum[1:0];
                phase_next    = PH_PAD;
              end else begin
                column_count_next = '0;
                row_count_next    = row_inc;
              end
            end
          end
        endcase
      end

      PH_PAD: begin
        pad_left_next = cur_pad - 2'd1;
        if (cur_pad == 2'd1) begin
          column_count_next = '0;
          row_count_next    = row_inc;
          phase_next        = PH_PIXEL;
        end
      end

      PH_DONE, PH_ERROR: ;

      default: phase_next = PH_ERROR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HEADER;
      header_index  <= 6'd0;
      column_count  <= '0;
      row_count     <= '0;
      byte_in_pixel <= 2'd0;
      pad_left      <= 2'd0;
    end else if (accept) begin
      phase         <= phase_next;
      header_index  <= header_index_next;
      column_count  <= column_count_next;
      row_count     <= row_count_next;
      byte_in_pixel <= byte_in_pixel_next;
      pad_left      <= pad_left_next;
    end
  end

  // header fields are always rewritten before they are checked
  always_ff @(posedge clk) begin
    if (accept) begin
      offset_accum      <= offset_accum_next;
      width_accum       <= width_accum_next;
      height_accum      <= height_accum_next;
      depth_accum       <= depth_accum_next;
      compression_accum <= compression_accum_next;
      blue_hold         <= blue_hold_next;
      green_hold        <= green_hold_next;
    end
  end

  assign out.push = accept && res_valid;
  assign out.res  = res;

endmodule

// ===== design/bsp_fifo.sv =====
// Four-entry result queue between the parser and the output stage.
// Depends on bsp_pkg for the result record.
module bsp_fifo (
  input  logic             clk,
  input  logic             rst,
  input  bsp_pkg::push_t   wr,
  output logic             full,
  output logic             rd_valid,
  output bsp_pkg::result_t rd_data,
  input  logic             pop
);
  import bsp_pkg::*;

  localparam int DEPTH = 4;
  localparam int AW    = $clog2(DEPTH);

  result_t       mem [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [AW:0]   count;
  logic          do_pop;

  assign full     = (count == (AW + 1)'(DEPTH));
  assign rd_valid = (count != '0);
  assign rd_data  = mem[rd_ptr];
  assign do_pop   = pop && rd_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr.push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= rd_ptr + 1'b1;
      count <= count + (AW + 1)'(wr.push) - (AW + 1)'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (wr.push) mem[wr_ptr] <= wr.res;
  end

endmodule

// ===== design/bsp_back.sv =====
// Output stage: takes result records from the queue and presents them as beats.
// Packs the record into tdata, tuser and tlast. Depends on bsp_pkg.
module bsp_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  bsp_pkg::result_t q_data,
  output logic             q_pop,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [79:0]      m_axis_tdata,
  output logic [1:0]       m_axis_tuser,
  output logic             m_axis_tlast
);
  import bsp_pkg::*;

  logic load;

  // refill the output register whenever it is empty or being drained
  assign load  = !m_axis_tvalid || m_axis_tready;
  assign q_pop = load && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (load) begin
      m_axis_tvalid <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      m_axis_tdata <= {4'b0000, q_data.image_height, q_data.image_width,
                       q_data.error_code, q_data.row, q_data.column,
                       q_data.blue, q_data.green, q_data.red};
      m_axis_tuser <= q_data.kind;
      m_axis_tlast <= q_data.last_pixel;
    end
  end

endmodule

// ===== design/bmp24_stream_parser_core.sv =====
// 24-bit BMP stream parser, one file byte per beat, results as beats.
// Throughput: one byte per cycle while the queue has room, set by byte-serial counters.
// A result is written into the queue as its byte is accepted, then moved to the output register.
// A four-entry queue lets input continue while a result waits at the output.
// Reset (rst, synchronous, active high) returns to the header phase and empties the queue.
// Depends on bsp_pkg, bsp_front, bsp_fifo and bsp_back.
module bmp24_stream_parser_core #(
  parameter int MAX_DIM = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tuser,   // [0] start_of_file
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] red, [15:8] green, [23:16] blue, [35:24] column, [47:36] row,
  // [49:48] error_code, [62:50] image_width, [75:63] image_height, [79:76] zero
  output logic [79:0] m_axis_tdata,
  output logic [1:0]  m_axis_tuser,   // [1:0] kind
  output logic        m_axis_tlast    // last_pixel
);
  import bsp_pkg::*;

  push_t   push;
  logic    q_full, q_valid, q_pop, accept;
  result_t q_data;

  assign s_axis_tready = !q_full;
  assign accept        = s_axis_tvalid && s_axis_tready;

  bsp_front #(
    .MAX_DIM(MAX_DIM)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .data_byte    (s_axis_tdata),
    .start_of_file(s_axis_tuser),
    .out          (push)
  );

  bsp_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr      (push),
    .full    (q_full),
    .rd_valid(q_valid),
    .rd_data (q_data),
    .pop     (q_pop)
  );

  bsp_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_data       (q_data),
    .q_pop        (q_pop),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

endmodule

// ===== dv/bmp24_stream_parser_core_test.sv =====
// Self-checking bench for bmp24_stream_parser_core: streams BMP files byte by byte and
// compares every result beat with the beats that its own parser model predicts.
// Depends on bsp_pkg and the bmp24_stream_parser_core RTL.
module bmp24_stream_parser_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import bsp_pkg::*;

  localparam int unsigned MAX_DIM     = 4096;
  localparam int unsigned ITEM_TARGET = 1050;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned TAIL_CYCLES = 20;

  typedef logic [7:0] bytes_t[$];

  typedef enum logic [2:0] {
    ST_HEADER,
    ST_PIXEL,
    ST_PAD,
    ST_DONE,
    ST_ERROR
  } parse_phase_t;

  typedef enum int {
    SH_GOOD,
    SH_BAD_MAGIC,
    SH_BAD_OFFSET,
    SH_BAD_FORMAT,
    SH_BAD_SIZE,
    SH_BAD_BOTH,
    SH_BIG_HEADER,
    SH_CUT_HEADER,
    SH_NOISE,
    SH_COUNT
  } file_shape_t;

  // Byte-serial model of the parser plus the queue of beats it still owes.
  class bmp_result_tracker;
    result_t      expected_beats[$];
    int unsigned  errors;
    parse_phase_t phase;
    logic [5:0]   hdr_idx;
    logic [31:0]  offset, width, height, comp;
    logic [15:0]  depth;
    int unsigned  col, row;
    logic [1:0]   byte_pos, pad;
    logic [7:0]   blue_h, green_h;

    function new();
      errors = 0;
      clear();
    endfunction

    function void clear();
      phase    = ST_HEADER;
      hdr_idx  = '0;
      offset   = '0;
      width    = '0;
      height   = '0;
      comp     = '0;
      depth    = '0;
      col      = 0;
      row      = 0;
      byte_pos = '0;
      pad      = '0;
      blue_h   = '0;
      green_h  = '0;
    endfunction

    function bit flag_error(err_t code, output result_t r);
      r            = '0;
      r.kind       = KIND_ERROR;
      r.error_code = code;
      phase        = ST_ERROR;
      return 1'b1;
    endfunction

    function bit dim_good(logic [31:0] v);
      return !v[31] && v >= 1 && v <= MAX_DIM;
    endfunction

    function void next_row();
      col = 0;
      row++;
      phase = (row >= height) ? ST_DONE : ST_PIXEL;
    endfunction

    function bit parse_byte(logic [7:0] b, logic sof, output result_t r);
      int unsigned i;
      r = '0;
      if (sof) clear();
      case (phase)
        ST_HEADER: begin
          i = hdr_idx;
          hdr_idx = hdr_idx + 6'd1;
          if (i == IDX_MAGIC0 && b != MAGIC_B) return flag_error(ERR_MAGIC, r);
          if (i == IDX_MAGIC1 && b != MAGIC_M) return flag_error(ERR_MAGIC, r);
          if (i >= IDX_OFF0 && i <= IDX_OFF3) offset |= 32'(b) << (8 * (i - IDX_OFF0));
          if (i >= IDX_WID0 && i <= IDX_WID3) width |= 32'(b) << (8 * (i - IDX_WID0));
          if (i >= IDX_HGT0 && i <= IDX_HGT3) height |= 32'(b) << (8 * (i - IDX_HGT0));
          if (i >= IDX_DEP0 && i <= IDX_DEP1) depth |= 16'(b) << (8 * (i - IDX_DEP0));
          if (i >= IDX_CMP0 && i <= IDX_CMP3) comp |= 32'(b) << (8 * (i - IDX_CMP0));
          if (i == IDX_OFF3 && offset != PIX_OFFSET) return flag_error(ERR_OFFSET, r);
          if (i == IDX_LAST) begin
            // format check takes precedence over the size check
            if (depth != PIX_DEPTH || comp != 0) return flag_error(ERR_FORMAT, r);
            if (!dim_good(width) || !dim_good(height)) return flag_error(ERR_SIZE, r);
            phase          = ST_PIXEL;
            r.kind         = KIND_HEADER;
            r.image_width  = width[12:0];
            r.image_height = height[12:0];
            return 1'b1;
          end
          return 1'b0;
        end
        ST_PIXEL: begin
          if (byte_pos == 2'd0) begin
            blue_h   = b;
            byte_pos = 2'd1;
            return 1'b0;
          end
          if (byte_pos == 2'd1) begin
            green_h  = b;
            byte_pos = 2'd2;
            return 1'b0;
          end
          byte_pos     = 2'd0;
          r.kind       = KIND_PIXEL;
          r.red        = b;
          r.green      = green_h;
          r.blue       = blue_h;
          r.column     = col[11:0];
          r.row        = row[11:0];
          r.last_pixel = (col + 1 == width) && (row + 1 == height);
          col++;
          if (col >= width) begin
            if (row + 1 >= height) begin
              phase = ST_DONE;
            end else begin
              pad = 2'(4 - ((width * 3) & 3));
              if (pad != 2'd0) phase = ST_PAD;
              else next_row();
            end
          end
          return 1'b1;
        end
        ST_PAD: begin
          pad = pad - 2'd1;
          if (pad == 2'd0) next_row();
          return 1'b0;
        end
        default: return 1'b0;
      endcase
    endfunction

    function void note_byte(logic [7:0] b, logic sof);
      result_t r;
      if (parse_byte(b, sof, r)) expected_beats.push_back(r);
    endfunction

    function void cmp_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_beat(logic [79:0] data, logic [1:0] user, logic tl);
      result_t want;
      if (expected_beats.size() == 0) begin
        $error("unexpected result beat: kind %0d data 0x%0h", user, data);
        errors++;
        return;
      end
      want = expected_beats.pop_front();
      cmp_field("kind", want.kind, user);
      cmp_field("red", want.red, data[7:0]);
      cmp_field("green", want.green, data[15:8]);
      cmp_field("blue", want.blue, data[23:16]);
      cmp_field("column", want.column, data[35:24]);
      cmp_field("row", want.row, data[47:36]);
      cmp_field("last_pixel", want.last_pixel, tl);
      cmp_field("error_code", want.error_code, data[49:48]);
      cmp_field("image_width", want.image_width, data[62:50]);
      cmp_field("image_height", want.image_height, data[75:63]);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;   // [7:0] data_byte
  logic        s_axis_tuser = 1'b0; // [0] start_of_file
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [79:0] m_axis_tdata;        // red, green, blue, column, row, error_code, width, height
  logic [1:0]  m_axis_tuser;        // [1:0] kind
  logic        m_axis_tlast;        // last_pixel

  bit          steady   = 1'b0;
  bit          hold_req = 1'b0;
  int unsigned parsed_bytes = 0;

  bmp_result_tracker sb = new();

  bmp24_stream_parser_core #(
    .MAX_DIM(MAX_DIM)
  ) u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result side: random back-pressure, plus one long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      m_axis_tready = steady || ($urandom_range(99) >= 6);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) sb.check_beat(m_axis_tdata, m_axis_tuser, m_axis_tlast);
  end

  // entered and left at a falling edge
  task automatic send_byte(logic [7:0] b, logic sof);
    while (!steady && $urandom_range(99) < 6) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = b;
    s_axis_tuser  = sof;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_byte(b, sof);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    s_axis_tvalid = 1'b0;
    while (sb.expected_beats.size() != 0) @(negedge clk);
  endtask

  function automatic bytes_t header_bytes(logic [7:0] m0, logic [7:0] m1, logic [31:0] off,
                                          logic [31:0] wd, logic [31:0] ht,
                                          logic [15:0] dep, logic [31:0] cmp);
    bytes_t     h;
    logic [7:0] b;
    for (int i = 0; i < HDR_LEN; i++) begin
      b = 8'($urandom);
      if (i == IDX_MAGIC0) b = m0;
      else if (i == IDX_MAGIC1) b = m1;
      else if (i >= IDX_OFF0 && i <= IDX_OFF3) b = 8'(off >> (8 * (i - IDX_OFF0)));
      else if (i >= IDX_WID0 && i <= IDX_WID3) b = 8'(wd >> (8 * (i - IDX_WID0)));
      else if (i >= IDX_HGT0 && i <= IDX_HGT3) b = 8'(ht >> (8 * (i - IDX_HGT0)));
      else if (i >= IDX_DEP0 && i <= IDX_DEP1) b = 8'(dep >> (8 * (i - IDX_DEP0)));
      else if (i >= IDX_CMP0 && i <= IDX_CMP3) b = 8'(cmp >> (8 * (i - IDX_CMP0)));
      h.push_back(b);
    end
    return h;
  endfunction

  function automatic logic [7:0] other_than(logic [7:0] v);
    logic [7:0] b;
    do b = 8'($urandom); while (b == v);
    return b;
  endfunction

  function automatic logic [31:0] bad_dim();
    case ($urandom_range(5))
      0: return 32'd0;
      1: return 32'h8000_0000;
      2: return 32'hFFFF_FFFF;
      3: return MAX_DIM + 1;
      4: return $urandom_range(32'h7FFF_FFFF, MAX_DIM + 1);
      default: return $urandom | 32'h8000_0000;
    endcase
  endfunction

  task automatic send_shape(file_shape_t shape, int unsigned w, int unsigned h);
    bytes_t      f;
    int unsigned live, extra;
    logic [31:0] off, wd, ht, cmp;
    logic [15:0] dep;
    logic [7:0]  m0, m1;
    m0   = MAGIC_B;
    m1   = MAGIC_M;
    off  = PIX_OFFSET;
    dep  = PIX_DEPTH;
    cmp  = '0;
    wd   = ($urandom_range(3) == 0) ? MAX_DIM : w;
    ht   = ($urandom_range(3) == 0) ? MAX_DIM : h;
    live = HDR_LEN;
    case (shape)
      SH_GOOD: begin
        wd = w;
        ht = h;
      end
      SH_BAD_MAGIC: begin
        if ($urandom_range(1)) begin
          m0   = other_than(MAGIC_B);
          live = 1;
        end else begin
          m1   = other_than(MAGIC_M);
          live = 2;
        end
      end
      SH_BAD_OFFSET: begin
        off  = $urandom_range(1) ? (PIX_OFFSET ^ (32'd1 << $urandom_range(31))) : $urandom;
        if (off == PIX_OFFSET) off = ~PIX_OFFSET;
        live = IDX_OFF3 + 1;
      end
      SH_BAD_FORMAT, SH_BAD_BOTH: begin
        if ($urandom_range(1)) dep = PIX_DEPTH ^ (16'd1 << $urandom_range(15));
        else cmp = $urandom_range(1) ? (32'd1 << $urandom_range(31)) : ($urandom | 32'd1);
        if (shape == SH_BAD_BOTH) wd = bad_dim();
      end
      SH_BAD_SIZE: begin
        case ($urandom_range(2))
          0: wd = bad_dim();
          1: ht = bad_dim();
          default: begin
            wd = bad_dim();
            ht = bad_dim();
          end
        endcase
      end
      SH_BIG_HEADER: begin
        wd = $urandom_range(1) ? MAX_DIM : $urandom_range(MAX_DIM, 1);
        ht = $urandom_range(1) ? MAX_DIM : $urandom_range(MAX_DIM, 1);
      end
      SH_CUT_HEADER: live = $urandom_range(HDR_LEN - 1, 2);
      default: live = 0;
    endcase
    f = header_bytes(m0, m1, off, wd, ht, dep, cmp);
    if (shape == SH_GOOD) begin
      // each row carries its pad bytes, the last row's included
      for (int r = 0; r < h; r++)
        for (int c = 0; c < w * 3 + ((4 - ((w * 3) % 4)) % 4); c++) f.push_back(8'($urandom));
      live = f.size();
    end
    if (shape == SH_BIG_HEADER) begin
      repeat ($urandom_range(30)) f.push_back(8'($urandom));
      live = f.size();
    end
    while (f.size() > live) void'(f.pop_back());
    extra = (shape == SH_NOISE) ? $urandom_range(12, 1) : $urandom_range(4);
    repeat (extra) f.push_back(8'($urandom));
    parsed_bytes += live;
    foreach (f[i]) begin
      if (shape == SH_NOISE) send_byte(f[i], $urandom_range(7) == 0);
      else send_byte(f[i], i == 0);
    end
  endtask

  initial begin
    int unsigned file_no;
    file_shape_t shape;
    int unsigned r;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // magic errors, the first one without a start marker straight after reset
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(MAGIC_B, 1'b0);
    send_byte(MAGIC_B, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(MAGIC_B, 1'b1);
    send_byte(MAGIC_M, 1'b0);
    send_byte(MAGIC_B, 1'b1);
    send_byte(MAGIC_B, 1'b0);
    send_byte(MAGIC_M, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);

    // stall the result side long enough to back up the queue, then drain
    hold_req = 1'b1;
    send_shape(SH_GOOD, 7, 4);
    wait_drained();

    file_no = 0;
    while (parsed_bytes < ITEM_TARGET) begin
      steady = (file_no >= 12 && file_no < 16);
      if (file_no < SH_COUNT) begin
        shape = file_shape_t'(file_no);
      end else begin
        r = $urandom_range(99);
        if (r < 55) shape = SH_GOOD;
        else if (r < 63) shape = SH_BAD_MAGIC;
        else if (r < 70) shape = SH_BAD_OFFSET;
        else if (r < 77) shape = SH_BAD_FORMAT;
        else if (r < 84) shape = SH_BAD_SIZE;
        else if (r < 87) shape = SH_BAD_BOTH;
        else if (r < 92) shape = SH_BIG_HEADER;
        else if (r < 96) shape = SH_CUT_HEADER;
        else shape = SH_NOISE;
      end
      send_shape(shape, $urandom_range(7, 1), $urandom_range(4, 1));
      file_no++;
    end
    steady = 1'b0;

    s_axis_tvalid = 1'b0;
    while (sb.expected_beats.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
